[design/lps_pkg.sv]
// Shared types and constants for the line pixel stepper.
// No dependencies; imported by every module of the block.

package lps_pkg;

	// Defaults for the top-level geometry parameters
	localparam int unsigned SCREEN_W_DEF  = 1024;
	localparam int unsigned TOTAL_PIX_DEF = 1048576;

	localparam int COORD_W = 12;                    // endpoint coordinates
	localparam int RISE_W  = COORD_W + 1;           // coordinate differences
	localparam int FRAC_W  = 16;                    // Q12.16 fraction bits
	localparam int QUO_W   = COORD_W + FRAC_W;      // slope magnitude
	localparam int SLOPE_W = QUO_W + 1;             // signed slope
	localparam int PROD_W  = SLOPE_W + COORD_W;     // slope times coordinate
	localparam int ICPT_W  = PROD_W + 1 - FRAC_W + 1;
	localparam int B_W     = ICPT_W - 1 + FRAC_W;   // intercept numerator
	localparam int PY_W    = PROD_W + 3 - FRAC_W;   // pixel row
	localparam int V_W     = PY_W + FRAC_W;         // row numerator
	localparam int OFF_W   = 32;                    // framebuffer offset
	localparam int ADDR_W  = 20;
	localparam int COLOR_W = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(QUO_W + 1);

	typedef enum logic [0:0] {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		MODE_VERT  = 2'd0,
		MODE_HOR   = 2'd1,
		MODE_SLOPE = 2'd2
	} mode_t;

	// One classified transaction as it sits in the queue
	typedef struct packed {
		logic                       is_step;
		mode_t                      mode;
		logic signed [COORD_W-1:0]  step_c;
		logic signed [COORD_W-1:0]  stop_c;
		logic signed [COORD_W-1:0]  fixed_c;
		logic signed [RISE_W-1:0]   rise;
		logic signed [RISE_W-1:0]   run;
		logic signed [COORD_W-1:0]  x_end;
		logic signed [COORD_W-1:0]  y_end;
		logic        [COLOR_W-1:0]  color;
	} lps_item_t;

	typedef struct packed {
		logic                       start;
		logic signed [RISE_W-1:0]   rise;
		logic signed [RISE_W-1:0]   run;
	} lps_div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [SLOPE_W-1:0]  quot;
	} lps_div_rsp_t;

endpackage

[design/lps_front.sv]
// Front end: classifies an incoming transaction into a queue record.
// Picks the line mode, orders the walking range and forms rise and run.
// Depends on lps_pkg.

module lps_front
	import lps_pkg::*;
(
	input  logic                       func,
	input  logic signed [COORD_W-1:0]  x_start,
	input  logic signed [COORD_W-1:0]  y_start,
	input  logic signed [COORD_W-1:0]  x_end,
	input  logic signed [COORD_W-1:0]  y_end,
	input  logic        [COLOR_W-1:0]  pixel_color,
	output lps_item_t                  item
);

	logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;

	always_comb begin
		x_lo = (x_start < x_end) ? x_start : x_end;
		x_hi = (x_start < x_end) ? x_end : x_start;
		y_lo = (y_start < y_end) ? y_start : y_end;
		y_hi = (y_start < y_end) ? y_end : y_start;

		item.is_step = (func_t'(func) == FUNC_STEP);
		item.rise    = {y_end[COORD_W-1], y_end} - {y_start[COORD_W-1], y_start};
		item.run     = {x_end[COORD_W-1], x_end} - {x_start[COORD_W-1], x_start};
		item.x_end   = x_end;
		item.y_end   = y_end;
		item.color   = pixel_color;

		if (x_start == x_end) begin
			// equal endpoints land here too: one pixel at the endpoint
			item.mode    = MODE_VERT;
			item.fixed_c = x_start;
			item.step_c  = y_lo;
			item.stop_c  = y_hi;
		end else if (y_start == y_end) begin
			item.mode    = MODE_HOR;
			item.fixed_c = y_start;
			item.step_c  = x_lo;
			item.stop_c  = x_hi;
		end else begin
			item.mode    = MODE_SLOPE;
			item.fixed_c = '0;
			item.step_c  = x_lo;
			item.stop_c  = x_hi;
		end
	end

endmodule

[design/lps_queue.sv]
// Short FIFO of classified transactions between front and back end.
// Depends on lps_pkg.

module lps_queue
	import lps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lps_item_t  wr_item,
	input  logic       pop,
	output lps_item_t  rd_item,
	output logic       not_empty,
	output logic       not_full
);

	lps_item_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]    count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign not_empty = (count_q != '0);
	assign not_full  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[design/lps_div.sv]
// Serial signed divider for the slope: (rise * 2^16) / run, truncated.
// Restoring division on magnitudes, one quotient bit per cycle.
// Depends on lps_pkg.

module lps_div
	import lps_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  lps_div_req_t  req,
	output lps_div_rsp_t  rsp
);

	logic                  busy_q, done_q, neg_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [QUO_W-1:0]      acc_q;     // dividend bits shift out, quotient bits in
	logic [COORD_W-1:0]    rem_q;
	logic [COORD_W-1:0]    dvs_q;

	logic [RISE_W-1:0]     rise_mag, run_mag;
	logic [COORD_W:0]      trial;
	logic                  ge;
	logic [COORD_W-1:0]    rem_nxt;
	logic [SLOPE_W-1:0]    quot_ext;

	always_comb begin
		rise_mag = req.rise[RISE_W-1] ? (RISE_W'(0) - req.rise) : req.rise;
		run_mag  = req.run[RISE_W-1]  ? (RISE_W'(0) - req.run)  : req.run;
		trial    = {rem_q, acc_q[QUO_W-1]};
		ge       = (trial >= {1'b0, dvs_q});
		rem_nxt  = ge ? COORD_W'(trial - {1'b0, dvs_q}) : trial[COORD_W-1:0];
		quot_ext = {1'b0, acc_q};
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? $signed(SLOPE_W'(0) - quot_ext) : $signed(quot_ext);

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= {rise_mag[COORD_W-1:0], {FRAC_W{1'b0}}};
			rem_q <= '0;
			dvs_q <= run_mag[COORD_W-1:0];
			neg_q <= req.rise[RISE_W-1] ^ req.run[RISE_W-1];
		end else if (busy_q) begin
			acc_q <= {acc_q[QUO_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[design/lps_back.sv]
// Back end: holds the line state, runs the sloped-line load sequence (divide, multiply,
// intercept) and the step pipeline s1..s3 plus the output register.
// Depends on lps_pkg; drives lps_div through its request struct.

module lps_back
	import lps_pkg::*;
#(
	parameter int unsigned SCREEN_W  = SCREEN_W_DEF,
	parameter int unsigned TOTAL_PIX = TOTAL_PIX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lps_item_t            q_item,
	input  logic                 q_avail,
	output logic                 q_pop,
	output lps_div_req_t         div_req,
	input  lps_div_rsp_t         div_rsp,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 pixel_valid,
	output logic                 write_enable,
	output logic [ADDR_W-1:0]    address,
	output logic [COLOR_W-1:0]   color_out,
	output logic                 last
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_ICPT = 4'b1000
	} st_t;

	st_t state_q;

	// line state
	logic                       active_q;
	mode_t                      mode_q;
	logic signed [COORD_W-1:0]  step_q, stop_q, fixed_q, xend_q, yend_q;
	logic signed [SLOPE_W-1:0]  slope_q;
	logic signed [ICPT_W-1:0]   icpt_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic        [COLOR_W-1:0]  color_q;

	// step pipeline
	logic                       vld_s1, vld_s2, vld_s3;
	logic                       act_s1, act_s2, act_s3;
	logic                       last_s1, last_s2, last_s3;
	logic                       slp_s1;
	logic signed [COORD_W-1:0]  px_s1, px_s2, ypl_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ICPT_W-1:0]   icpt_s1;
	logic        [COLOR_W-1:0]  color_s1, color_s2, color_s3;
	logic signed [PY_W-1:0]     py_s2;
	logic        [OFF_W-1:0]    off_s3;

	// output register
	logic                       res_valid_q, pix_q, we_q, last_q;
	logic        [ADDR_W-1:0]   addr_q;
	logic        [COLOR_W-1:0]  color_q_out;

	logic                       en, take_step, take_load;
	logic signed [B_W-1:0]      b_num;
	logic signed [ICPT_W-1:0]   icpt_nxt;
	logic signed [V_W-1:0]      v_num;
	logic signed [PY_W-1:0]     py_slope;
	logic        [OFF_W-1:0]    py_ext, px_ext;

	assign en        = !res_valid_q || res_ready;
	assign take_step = (state_q == ST_IDLE) && q_avail && q_item.is_step && en;
	assign take_load = (state_q == ST_IDLE) && q_avail && !q_item.is_step;
	assign q_pop     = take_step || take_load;

	assign div_req.start = take_load && (q_item.mode == MODE_SLOPE);
	assign div_req.rise  = q_item.rise;
	assign div_req.run   = q_item.run;

	always_comb begin
		// intercept = trunc((y_end * 2^16 - slope * x_end) / 2^16)
		b_num    = (B_W'(yend_q) <<< FRAC_W) - B_W'(prod_q);
		icpt_nxt = ICPT_W'($signed(b_num[B_W-1:FRAC_W]))
		         + ICPT_W'(b_num[B_W-1] && (b_num[FRAC_W-1:0] != '0));
		// row = trunc((slope * x + intercept * 2^16) / 2^16)
		v_num    = V_W'(prod_s1) + (V_W'(icpt_s1) <<< FRAC_W);
		py_slope = $signed(v_num[V_W-1:FRAC_W])
		         + PY_W'(v_num[V_W-1] && (v_num[FRAC_W-1:0] != '0));
		py_ext   = {{(OFF_W-PY_W){py_s2[PY_W-1]}}, py_s2};
		px_ext   = {{(OFF_W-COORD_W){px_s2[COORD_W-1]}}, px_s2};
	end

	// load sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (div_req.start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done)
						state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_ICPT;
				ST_ICPT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mode_q   <= MODE_VERT;
			step_q   <= '0;
			stop_q   <= '0;
			fixed_q  <= '0;
			slope_q  <= '0;
			icpt_q   <= '0;
			color_q  <= '0;
			xend_q   <= '0;
			yend_q   <= '0;
			prod_q   <= '0;
		end else begin
			if (take_load) begin
				active_q <= 1'b1;
				mode_q   <= q_item.mode;
				step_q   <= q_item.step_c;
				stop_q   <= q_item.stop_c;
				fixed_q  <= q_item.fixed_c;
				color_q  <= q_item.color;
				xend_q   <= q_item.x_end;
				yend_q   <= q_item.y_end;
				slope_q  <= '0;
				icpt_q   <= '0;
			end else if (take_step && active_q) begin
				if (step_q >= stop_q)
					active_q <= 1'b0;
				else
					step_q <= step_q + 1'b1;
			end
			if ((state_q == ST_DIV) && div_rsp.done)
				slope_q <= div_rsp.quot;
			if (state_q == ST_MUL)
				prod_q <= slope_q * xend_q;
			if (state_q == ST_ICPT)
				icpt_q <= icpt_nxt;
		end
	end

	// step pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= take_step;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			res_valid_q <= vld_s3;
		end
	end

	// step pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: pick coordinates, slope * x
			act_s1   <= active_q;
			last_s1  <= active_q && (step_q >= stop_q);
			slp_s1   <= (mode_q == MODE_SLOPE);
			px_s1    <= (mode_q == MODE_VERT) ? fixed_q : step_q;
			ypl_s1   <= (mode_q == MODE_HOR) ? fixed_q : step_q;
			prod_s1  <= slope_q * step_q;
			icpt_s1  <= icpt_q;
			color_s1 <= color_q;
			// s2: row
			act_s2   <= act_s1;
			last_s2  <= last_s1;
			px_s2    <= px_s1;
			py_s2    <= slp_s1 ? py_slope : PY_W'(ypl_s1);
			color_s2 <= color_s1;
			// s3: linear offset
			act_s3   <= act_s2;
			last_s3  <= last_s2;
			off_s3   <= OFF_W'(SCREEN_W) * py_ext + px_ext;
			color_s3 <= color_s2;
			// output: range check, blank fields for an idle step
			pix_q       <= act_s3;
			we_q        <= act_s3 && (off_s3 < OFF_W'(TOTAL_PIX));
			addr_q      <= act_s3 ? off_s3[ADDR_W-1:0] : '0;
			color_q_out <= act_s3 ? color_s3 : '0;
			last_q      <= last_s3;
		end
	end

	assign res_valid    = res_valid_q;
	assign pixel_valid  = pix_q;
	assign write_enable = we_q;
	assign address      = addr_q;
	assign color_out    = color_q_out;
	assign last         = last_q;

endmodule

[design/line_pixel_stepper_unit.sv]
// Line pixel stepper, top level: front classifier, transaction queue,
// serial slope divider and back-end step pipeline.
// Depends on lps_pkg, lps_front, lps_queue, lps_div, lps_back.
//
// Usage:
//  - Command channel (cmd_valid/cmd_ready): func 0 loads a line from the
//    two endpoints and pixel_color; func 1 asks for the next pixel.
//  - Result channel (res_valid/res_ready): one transaction per step command,
//    none per load. pixel_valid is 0 (all fields 0) when no line is active.
//    write_enable drops when SCREEN_W*y+x falls outside the framebuffer;
//    last marks the final pixel of the line.
//  - Path of a step after its command is accepted: the queue, then
//    s1 coordinate/product, s2 row, s3 offset, output reg.
//  - Throughput: steps stream at one per cycle while no load is in progress
//    and the receiver is not stalling. A vertical or horizontal load
//    is taken in the idle state; a sloped load holds the back end through the
//    bit-serial divider (28 quotient bits), intercept multiply and correction.
//  - The 2-entry queue keeps taking commands while the back end divides or
//    the receiver stalls; cmd_ready drops only when the queue is full.
//  - A receiver stall freezes the whole step pipeline in place.
//  - Reset clears the queue, the pipeline and the line state: a step after
//    reset returns an all-zero result.

module line_pixel_stepper_unit
	import lps_pkg::*;
#(
	parameter int unsigned SCREEN_W  = SCREEN_W_DEF,
	parameter int unsigned TOTAL_PIX = TOTAL_PIX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic                       func,
	input  logic signed [COORD_W-1:0]  x_start,
	input  logic signed [COORD_W-1:0]  y_start,
	input  logic signed [COORD_W-1:0]  x_end,
	input  logic signed [COORD_W-1:0]  y_end,
	input  logic        [COLOR_W-1:0]  pixel_color,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       pixel_valid,
	output logic                       write_enable,
	output logic        [ADDR_W-1:0]   address,
	output logic        [COLOR_W-1:0]  color_out,
	output logic                       last
);

	lps_item_t     front_item, head_item;
	logic          q_push, q_pop, q_avail, q_not_full;
	lps_div_req_t  div_req;
	lps_div_rsp_t  div_rsp;

	assign cmd_ready = q_not_full;
	assign q_push    = cmd_valid && cmd_ready;

	// classify the incoming transaction
	lps_front u_front (
		.func        (func),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.pixel_color (pixel_color),
		.item        (front_item)
	);

	// decouples command intake from the back end
	lps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_item   (front_item),
		.pop       (q_pop),
		.rd_item   (head_item),
		.not_empty (q_avail),
		.not_full  (q_not_full)
	);

	// slope divider, started by the back end on a sloped load
	lps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lps_back #(
		.SCREEN_W  (SCREEN_W),
		.TOTAL_PIX (TOTAL_PIX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (head_item),
		.q_avail      (q_avail),
		.q_pop        (q_pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.pixel_valid  (pixel_valid),
		.write_enable (write_enable),
		.address      (address),
		.color_out    (color_out),
		.last         (last)
	);

	// an idle-line step carries nothing
	a_idle_step_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !pixel_valid |-> !write_enable && !last && (address == '0)
		&& (color_out == '0))
		else $error("idle step result carries nonzero fields");

	// last only on a real pixel
	a_last_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |-> pixel_valid)
		else $error("last set without pixel_valid");

	// queue fills only through accepted commands
	a_ready_falls_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd_ready) |-> $past(cmd_valid))
		else $error("cmd_ready dropped without an accepted command");

	// the divider starts only when a load leaves the queue
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> q_pop)
		else $error("divider started without a load leaving the queue");

endmodule
